/* hdl/position_zoom_tween_animator_assert.svh */
// ----------------------------------------------------------------------------
// Position / zoom tween animator assertion macros
// Same-cycle and next-cycle implication checks on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef POSITION_ZOOM_TWEEN_ANIMATOR_ASSERT_SVH
`define POSITION_ZOOM_TWEEN_ANIMATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PZT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("pzt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PZT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("pzt: next-cycle check failed");

`endif

/* hdl/pzt_pkg.sv */
// ----------------------------------------------------------------------------
// pzt_pkg
// Shared constants, codes and types of the position / zoom tween animator.
// ----------------------------------------------------------------------------
package pzt_pkg;

    // Frames in one run.
    localparam int FRAME_COUNT = 16;

    // Frame counter holds 0 .. FRAME_COUNT; a live frame holds 0 .. FRAME_COUNT-1.
    localparam int FRAME_W = $clog2(FRAME_COUNT + 1);
    localparam int IDX_W   = $clog2(FRAME_COUNT);

    localparam int COORD_W = 13;
    localparam int ZOOM_W  = 10;
    localparam int MAG_W   = COORD_W;

    // Divide by FRAME_COUNT-1 as multiply by a floored reciprocal plus one fix-up.
    localparam int PROD_W  = MAG_W + IDX_W;
    localparam int RECIP_W = PROD_W + 1;
    localparam int WIDE_W  = PROD_W + RECIP_W;
    localparam int DIVISOR = FRAME_COUNT - 1;

    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << PROD_W) / DIVISOR);
    localparam logic [PROD_W-1:0]  DIVISOR_P = PROD_W'(DIVISOR);

    localparam logic [FRAME_W-1:0] FRAME_END   = FRAME_W'(FRAME_COUNT);
    localparam logic [FRAME_W-1:0] FRAME_LAST  = FRAME_W'(FRAME_COUNT - 1);
    localparam logic [FRAME_W-1:0] FRAME_FIRST = FRAME_W'(1);
    localparam logic [FRAME_W-1:0] FRAME_ZERO  = FRAME_W'(0);

    // Item kinds.
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Sync event codes.
    localparam logic [1:0] SYNC_NONE  = 2'd0;
    localparam logic [1:0] SYNC_ON    = 2'd1;
    localparam logic [1:0] SYNC_LEAVE = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [ZOOM_W-1:0]  zoom;
    } t_place;

    typedef struct packed {
        logic             fire;
        logic [IDX_W-1:0] frame;
        logic [1:0]       sev;
    } t_push;

    typedef struct packed {
        logic s0;
        logic s1;
        logic s2;
        logic res;
    } t_stage_ld;

endpackage

/* hdl/pzt_ctrl.sv */
// ----------------------------------------------------------------------------
// pzt_ctrl
// Placement state, frame counter and sync tracking; decides which ticks fire.
// ----------------------------------------------------------------------------
module pzt_ctrl
    import pzt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_mode,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic        [ZOOM_W-1:0]  i_target_zoom,
    input  logic                      i_target_fullscreen,
    output t_place                    o_src,
    output t_place                    o_goal,
    output t_push                     o_push
);

    t_place               r_src;
    t_place               r_goal;
    logic [FRAME_W-1:0]   r_frame;
    logic                 r_armed;
    logic                 r_shown_fs;
    logic                 r_goal_fs;

    logic                 live;
    logic                 fs_differs;
    logic [1:0]           sev;

    assign live       = r_armed && (r_frame != FRAME_END);
    assign fs_differs = r_shown_fs != r_goal_fs;

    always_comb begin
        priority if ((r_frame == FRAME_LAST) && r_goal_fs && fs_differs) begin
            sev = SYNC_ON;
        end else if ((r_frame == FRAME_FIRST) && !r_goal_fs && fs_differs) begin
            sev = SYNC_LEAVE;
        end else begin
            sev = SYNC_NONE;
        end
    end

    assign o_src        = r_src;
    assign o_goal       = r_goal;
    assign o_push.fire  = (i_mode == MODE_TICK) && live;
    assign o_push.frame = r_frame[IDX_W-1:0];
    assign o_push.sev   = sev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src      <= '0;
            r_goal     <= '0;
            r_frame    <= FRAME_ZERO;
            r_armed    <= 1'b0;
            r_shown_fs <= 1'b0;
            r_goal_fs  <= 1'b0;
        end else if (i_accept) begin
            if (i_mode == MODE_SET) begin
                // Shift the old goal to the source; the very first target jumps.
                r_src       <= r_goal;
                r_goal.x    <= i_target_x;
                r_goal.y    <= i_target_y;
                r_goal.zoom <= i_target_zoom;
                r_goal_fs   <= i_target_fullscreen;
                r_frame     <= r_armed ? FRAME_ZERO : FRAME_LAST;
                r_armed     <= 1'b1;
            end else if (live) begin
                r_frame <= r_frame + FRAME_W'(1);
                if (sev != SYNC_NONE) begin
                    r_shown_fs <= r_goal_fs;
                end
            end
        end
    end

endmodule

/* hdl/pzt_lane.sv */
// ----------------------------------------------------------------------------
// pzt_lane
// One coordinate: src + (goal - src) * frame / (FRAME_COUNT-1), truncated
// toward zero, over three registered steps and a result register.
// ----------------------------------------------------------------------------
module pzt_lane
    import pzt_pkg::*;
(
    input  logic                      i_clk,
    input  t_stage_ld                 i_ld,
    input  logic signed [COORD_W-1:0] i_src,
    input  logic signed [COORD_W-1:0] i_goal,
    input  logic        [IDX_W-1:0]   i_frame,
    output logic        [COORD_W-1:0] o_pos
);

    logic signed [COORD_W:0]   span;
    logic                      n_neg0;
    logic [MAG_W-1:0]          n_mag0;

    logic signed [COORD_W-1:0] r_src0, r_src1, r_src2;
    logic                      r_neg0, r_neg1, r_neg2;
    logic [MAG_W-1:0]          r_mag0;
    logic [PROD_W-1:0]         r_prod1, r_prod2;
    logic [PROD_W-1:0]         r_qest2;
    logic [COORD_W-1:0]        r_pos;

    logic [PROD_W-1:0]         n_prod1;
    logic [WIDE_W-1:0]         wide;
    logic [PROD_W-1:0]         n_qest2;
    logic [PROD_W-1:0]         qd;
    logic [PROD_W-1:0]         rem;
    logic [PROD_W-1:0]         quot;
    logic signed [COORD_W:0]   step;
    logic signed [COORD_W:0]   n_pos;

    // Split the span into sign and magnitude.
    assign span   = {i_goal[COORD_W-1], i_goal} - {i_src[COORD_W-1], i_src};
    assign n_neg0 = span[COORD_W];
    assign n_mag0 = n_neg0 ? MAG_W'(-span) : MAG_W'(span);

    assign n_prod1 = PROD_W'(r_mag0) * PROD_W'(i_frame);

    // Quotient estimate, at most one short of the true value.
    assign wide    = WIDE_W'(r_prod1) * WIDE_W'(RECIP);
    assign n_qest2 = wide[2*PROD_W-1:PROD_W];

    assign qd   = r_qest2 * DIVISOR_P;
    assign rem  = r_prod2 - qd;
    assign quot = (rem >= DIVISOR_P) ? (r_qest2 + PROD_W'(1)) : r_qest2;
    assign step = r_neg2 ? -$signed({1'b0, quot[MAG_W-1:0]})
                         :  $signed({1'b0, quot[MAG_W-1:0]});
    assign n_pos = {r_src2[COORD_W-1], r_src2} + step;

    assign o_pos = r_pos;

    always_ff @(posedge i_clk) begin
        if (i_ld.s0) begin
            r_src0 <= i_src;
            r_neg0 <= n_neg0;
            r_mag0 <= n_mag0;
        end
        if (i_ld.s1) begin
            r_src1  <= r_src0;
            r_neg1  <= r_neg0;
            r_prod1 <= n_prod1;
        end
        if (i_ld.s2) begin
            r_src2  <= r_src1;
            r_neg2  <= r_neg1;
            r_prod2 <= r_prod1;
            r_qest2 <= n_qest2;
        end
        if (i_ld.res) begin
            r_pos <= n_pos[COORD_W-1:0];
        end
    end

endmodule

/* hdl/position_zoom_tween_animator.sv */
// ----------------------------------------------------------------------------
// position_zoom_tween_animator
// Linear keyframe tween of an (x, y, zoom) placement with fullscreen sync.
// ----------------------------------------------------------------------------
// A set-target word (mode 0) stores a new goal placement, moves the old goal
// to the source and restarts a run of FRAME_COUNT frames; the first target
// after reset starts on the last frame, so the first tick lands on it. Each
// tick word (mode 1) inside a run returns one result word holding the
// interpolated x, y and zoom and a sync event: sync on when the last frame
// enters fullscreen, sync off when frame 1 leaves it. Set-target words and
// ticks outside a run return nothing. One word is taken every clock cycle
// unless the input is stalled; a result passes through four registers: the
// input register (span sign and magnitude, captured at the edge that takes
// its tick), two arithmetic registers (multiply by frame, multiply by
// the reciprocal of FRAME_COUNT-1) and the result register (fix-up and add).
// The input stalls only when all four of those registers are full and the
// output is stalled.
// ----------------------------------------------------------------------------
module position_zoom_tween_animator
    import pzt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_mode,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic        [ZOOM_W-1:0]  i_target_zoom,
    input  logic                      i_target_fullscreen,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_pos_x,
    output logic signed [COORD_W-1:0] o_pos_y,
    output logic        [ZOOM_W-1:0]  o_pos_zoom,
    output logic        [1:0]         o_sync_event
);

    t_place             src;
    t_place             goal;
    t_push              push;
    t_stage_ld          ld;

    logic               in_acc;
    logic               take0, take1, take2, take_res;

    logic               r_v0, r_v1, r_v2, r_out_valid;
    logic [IDX_W-1:0]   r_frame0;
    logic [1:0]         r_sev0, r_sev1, r_sev2, r_sev_out;

    logic [COORD_W-1:0] pos_x, pos_y, pos_z;

    // Each stage takes a new word when empty or when its contents move on.
    assign take_res = !r_out_valid || !i_out_stall;
    assign take2    = !r_v2 || take_res;
    assign take1    = !r_v1 || take2;
    assign take0    = !r_v0 || take1;

    assign o_in_stall = !take0;
    assign in_acc     = i_in_valid && take0;

    assign ld.s0  = take0;
    assign ld.s1  = take1;
    assign ld.s2  = take2;
    assign ld.res = take_res;

    pzt_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_accept            (in_acc),
        .i_mode              (i_mode),
        .i_target_x          (i_target_x),
        .i_target_y          (i_target_y),
        .i_target_zoom       (i_target_zoom),
        .i_target_fullscreen (i_target_fullscreen),
        .o_src               (src),
        .o_goal              (goal),
        .o_push              (push)
    );

    pzt_lane u_lane_x (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_src   (src.x),
        .i_goal  (goal.x),
        .i_frame (r_frame0),
        .o_pos   (pos_x)
    );

    pzt_lane u_lane_y (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_src   (src.y),
        .i_goal  (goal.y),
        .i_frame (r_frame0),
        .o_pos   (pos_y)
    );

    // Zoom is unsigned; widen with zeros so it runs on a signed lane.
    pzt_lane u_lane_z (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_src   ($signed({{(COORD_W - ZOOM_W){1'b0}}, src.zoom})),
        .i_goal  ($signed({{(COORD_W - ZOOM_W){1'b0}}, goal.zoom})),
        .i_frame (r_frame0),
        .o_pos   (pos_z)
    );

    // Valid bits: only a firing tick enters the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take0) begin
                r_v0 <= in_acc && push.fire;
            end
            if (take1) begin
                r_v1 <= r_v0;
            end
            if (take2) begin
                r_v2 <= r_v1;
            end
            if (take_res) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // Frame index and sync event ride along with the lanes; no reset needed.
    always_ff @(posedge i_clk) begin
        if (ld.s0) begin
            r_frame0 <= push.frame;
            r_sev0   <= push.sev;
        end
        if (ld.s1) begin
            r_sev1 <= r_sev0;
        end
        if (ld.s2) begin
            r_sev2 <= r_sev1;
        end
        if (ld.res) begin
            r_sev_out <= r_sev2;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pos_x      = pos_x;
    assign o_pos_y      = pos_y;
    assign o_pos_zoom   = pos_z[ZOOM_W-1:0];
    assign o_sync_event = r_sev_out;

`include "position_zoom_tween_animator_assert.svh"

    // A set-target word never puts anything into the pipeline.
    `PZT_ASSERT_NEXT(a_set_no_push, in_acc && (i_mode == MODE_SET), !r_v0)
    // Input stalls only when every stage is full and the output is held.
    `PZT_ASSERT_NOW(a_stall_full, o_in_stall,
        r_v0 && r_v1 && r_v2 && r_out_valid && i_out_stall)
    // A shown result carries a defined sync code.
    `PZT_ASSERT_NOW(a_sev_code, r_out_valid,
        (r_sev_out == SYNC_NONE) || (r_sev_out == SYNC_ON) || (r_sev_out == SYNC_LEAVE))

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the position / zoom tween animator.
// ----------------------------------------------------------------------------
// Words go in through the valid/stall input channel, and an in-bench tween
// model predicts every result word that a tick should return. A checker
// compares each result word, field by field, against the oldest prediction.
// The stimulus runs in this order:
//   - directed words: field extremes, the first target, a full run, sync on
//     and sync off, and ticks outside a run;
//   - random target/tick sequences with some noise mixed in;
//   - a back-to-back stretch with no idling on either side.
// Both sides idle at random for the rest of the run.
// ----------------------------------------------------------------------------
module tb_top;
    import pzt_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int STUCK_LIMIT = 1000;   // cycles with no word moving on either side
    localparam int SETTLE      = 8;      // pipeline is four deep; allow a margin

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [ZOOM_W-1:0]  zoom;
        logic        [1:0]         sev;
    } t_frame;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_mode;
    logic signed [COORD_W-1:0] i_target_x;
    logic signed [COORD_W-1:0] i_target_y;
    logic        [ZOOM_W-1:0]  i_target_zoom;
    logic                      i_target_fullscreen;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [COORD_W-1:0] o_pos_x;
    logic signed [COORD_W-1:0] o_pos_y;
    logic        [ZOOM_W-1:0]  o_pos_zoom;
    logic        [1:0]         o_sync_event;

    // Tween model state
    logic signed [COORD_W-1:0] from_x, from_y, to_x, to_y;
    logic        [ZOOM_W-1:0]  from_zoom, to_zoom;
    int                        frame_no;
    bit                        tween_live;
    bit                        screen_full;
    bit                        to_full;

    t_frame pending_frames[$];
    int     error_count;
    int     stuck_cycles;
    bit     quiet;          // set: neither side idles

    position_zoom_tween_animator DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_mode              (i_mode),
        .i_target_x          (i_target_x),
        .i_target_y          (i_target_y),
        .i_target_zoom       (i_target_zoom),
        .i_target_fullscreen (i_target_fullscreen),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_pos_x             (o_pos_x),
        .o_pos_y             (o_pos_y),
        .o_pos_zoom          (o_pos_zoom),
        .o_sync_event        (o_sync_event)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Linear step between a and b, division truncated toward zero.
    function automatic int tween_at(input int a, input int b, input int f);
        return a + ((b - a) * f) / (FRAME_COUNT - 1);
    endfunction

    // Advance the model by one accepted word and queue any result word it gives.
    task automatic advance_tween(input logic mode, input logic signed [COORD_W-1:0] x,
                                 input logic signed [COORD_W-1:0] y,
                                 input logic [ZOOM_W-1:0] z, input logic fs);
        t_frame nxt;
        if (mode == MODE_SET) begin
            from_x    = to_x;
            from_y    = to_y;
            from_zoom = to_zoom;
            to_x      = x;
            to_y      = y;
            to_zoom   = z;
            to_full   = fs;
            // the very first target jumps straight to the last frame
            frame_no   = tween_live ? 0 : FRAME_COUNT - 1;
            tween_live = 1'b1;
        end else if (tween_live && frame_no < FRAME_COUNT) begin
            nxt.x    = COORD_W'(tween_at(int'(from_x), int'(to_x), frame_no));
            nxt.y    = COORD_W'(tween_at(int'(from_y), int'(to_y), frame_no));
            nxt.zoom = ZOOM_W'(tween_at(int'(from_zoom), int'(to_zoom), frame_no));
            nxt.sev  = SYNC_NONE;
            if (frame_no == FRAME_COUNT - 1 && to_full && screen_full != to_full) begin
                nxt.sev     = SYNC_ON;
                screen_full = to_full;
            end
            if (frame_no == 1 && !to_full && screen_full != to_full) begin
                nxt.sev     = SYNC_LEAVE;
                screen_full = to_full;
            end
            frame_no++;
            pending_frames.push_back(nxt);
        end
    endtask

    // Send one word; valid stays high on return so the next word can follow at once.
    task automatic send_word(input logic mode, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic [ZOOM_W-1:0] z, input logic fs);
        while (!quiet && $urandom_range(99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_mode              <= mode;
        i_target_x          <= x;
        i_target_y          <= y;
        i_target_zoom       <= z;
        i_target_fullscreen <= fs;
        do @(posedge i_clk); while (o_in_stall);
        advance_tween(mode, x, y, z, fs);
    endtask

    // Tick words carry random junk in the ignored fields.
    task automatic send_tick();
        send_word(MODE_TICK, COORD_W'($urandom), COORD_W'($urandom),
                  ZOOM_W'($urandom), 1'($urandom));
    endtask

    // Drop valid and hold until every predicted result word has arrived.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_frames.size() != 0);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return COORD_W'(-(1 <<< (COORD_W - 1)));
            1:       return COORD_W'((1 <<< (COORD_W - 1)) - 1);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [ZOOM_W-1:0] pick_zoom();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return ZOOM_W'($urandom);
        endcase
    endfunction

    // Before any target, ticks give nothing; the first target lands on its last
    // frame, entering fullscreen, so sync on fires; ticks after the run give nothing.
    task automatic test_first_target();
        send_tick();
        send_word(MODE_SET, -13'sd4096, 13'sd4095, 10'd1023, 1'b1);
        send_tick();
        send_tick();
    endtask

    // Whole run from one extreme to the other, leaving fullscreen: sync off on frame 1.
    task automatic test_full_run();
        int n;
        send_word(MODE_SET, 13'sd4095, -13'sd4096, 10'd0, 1'b0);
        for (n = 0; n < FRAME_COUNT + 1; n++)
            send_tick();
    endtask

    // Mostly well-formed target/tick sequences, with noise and cut-short runs.
    task automatic test_random_tween();
        int seq_no;
        int n;
        int ticks;
        for (seq_no = 0; seq_no < 42; seq_no++) begin
            if ($urandom_range(9) == 0) begin
                for (n = 0; n < 10; n++)
                    send_word(1'($urandom), pick_coord(), pick_coord(), pick_zoom(),
                              1'($urandom));
            end else begin
                send_word(MODE_SET, pick_coord(), pick_coord(), pick_zoom(), 1'($urandom));
                ticks = ($urandom_range(9) < 7) ? $urandom_range(FRAME_COUNT + 2, FRAME_COUNT)
                                                : $urandom_range(FRAME_COUNT - 1);
                for (n = 0; n < ticks; n++)
                    send_tick();
            end
            // hold the sender now and then until the pipeline has emptied
            if (seq_no % 10 == 9)
                wait_drained();
        end
    endtask

    // Full-rate stretch: no idling on either side.
    task automatic test_back_to_back();
        int seq_no;
        int n;
        quiet = 1'b1;
        for (seq_no = 0; seq_no < 5; seq_no++) begin
            send_word(MODE_SET, pick_coord(), pick_coord(), pick_zoom(), 1'($urandom));
            for (n = 0; n < FRAME_COUNT; n++)
                send_tick();
        end
        wait_drained();
        quiet = 1'b0;
    endtask

    // Output stall: random, except in the quiet stretch.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_out_stall <= !quiet && ($urandom_range(99) < 24);
        end
    end

    // Compare each result word with the oldest prediction.
    always @(posedge i_clk) begin : check_frames
        t_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result word x %0d y %0d zoom %0d sync %0d",
                         $time, o_pos_x, o_pos_y, o_pos_zoom, o_sync_event);
                error_count++;
            end else begin
                want = pending_frames.pop_front();
                if (o_pos_x !== want.x) begin
                    $display("%0t: pos_x expected %0d, got %0d", $time, want.x, o_pos_x);
                    error_count++;
                end
                if (o_pos_y !== want.y) begin
                    $display("%0t: pos_y expected %0d, got %0d", $time, want.y, o_pos_y);
                    error_count++;
                end
                if (o_pos_zoom !== want.zoom) begin
                    $display("%0t: pos_zoom expected %0d, got %0d", $time, want.zoom,
                             o_pos_zoom);
                    error_count++;
                end
                if (o_sync_event !== want.sev) begin
                    $display("%0t: sync_event expected %0d, got %0d", $time, want.sev,
                             o_sync_event);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        error_count         = 0;
        stuck_cycles        = 0;
        quiet               = 1'b0;
        from_x              = '0;
        from_y              = '0;
        from_zoom           = '0;
        to_x                = '0;
        to_y                = '0;
        to_zoom             = '0;
        frame_no            = 0;
        tween_live          = 1'b0;
        screen_full         = 1'b0;
        to_full             = 1'b0;
        i_rst_n             <= 1'b0;
        i_in_valid          <= 1'b0;
        i_mode              <= MODE_SET;
        i_target_x          <= '0;
        i_target_y          <= '0;
        i_target_zoom       <= '0;
        i_target_fullscreen <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_first_target();
        test_full_run();
        test_random_tween();
        test_back_to_back();

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/pzt_pkg.sv
hdl/pzt_ctrl.sv
hdl/pzt_lane.sv
hdl/position_zoom_tween_animator.sv
bench/tb_top.sv
